// File: hw/rtl/fsd_pkg.sv
package fsd_pkg;

  // Defaults for the length limits of a sentence.
  localparam int unsigned MaxSentenceLenDef = 64;
  localparam int unsigned MaxPayloadLenDef  = 56;

  // Sentence length counter width; holds the largest allowed limit.
  localparam int unsigned LenW   = 7;
  localparam int unsigned FieldW = 16;

  // Framing and digit characters.
  localparam logic [7:0] ChStart = 8'h24;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChZero  = 8'd48;
  localparam logic [7:0] ChNine  = 8'd57;
  localparam logic [7:0] ChA     = 8'd65;
  localparam logic [7:0] ChF     = 8'd70;

  // Known sentence identifiers.
  localparam logic [23:0] IdCha = "CHA";
  localparam logic [23:0] IdAcc = "ACC";
  localparam logic [23:0] IdRev = "REV";
  localparam logic [23:0] IdSho = "SHO";
  localparam logic [23:0] IdRes = "RES";

  typedef enum logic [1:0] {
    PH_WAIT    = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_SUM     = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    TYPE_NONE = 3'd0,
    TYPE_CHA  = 3'd1,
    TYPE_ACC  = 3'd2,
    TYPE_REV  = 3'd3,
    TYPE_SHO  = 3'd4,
    TYPE_RES  = 3'd5
  } msg_type_e;

  // One result item as produced by the parser.
  typedef struct packed {
    logic              byte_error;
    logic              message_done;
    msg_type_e         message_type;
    logic [FieldW-1:0] field_one;
    logic [FieldW-1:0] field_two;
    logic [FieldW-1:0] field_three;
  } fsd_result_t;

endpackage

// File: hw/rtl/fsd_if.sv
interface fsd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

interface fsd_result_if;
  logic        valid;
  logic        ready;
  logic        byte_error;
  logic        message_done;
  logic [2:0]  message_type;
  logic [15:0] field_one;
  logic [15:0] field_two;
  logic [15:0] field_three;

  modport source (
    output valid, output byte_error, output message_done, output message_type,
    output field_one, output field_two, output field_three, input ready
  );
  modport sink (
    input valid, input byte_error, input message_done, input message_type,
    input field_one, input field_two, input field_three, output ready
  );
endinterface

// File: hw/rtl/fsd_parser.sv
module fsd_parser #(
  parameter int unsigned MaxSentenceLen = fsd_pkg::MaxSentenceLenDef,
  parameter int unsigned MaxPayloadLen  = fsd_pkg::MaxPayloadLenDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  output fsd_pkg::fsd_result_t result_o
);
  import fsd_pkg::*;

  localparam logic [LenW-1:0] SentLim = LenW'(MaxSentenceLen);
  // A payload byte is refused once the payload already holds the limit.
  localparam logic [LenW-1:0] PayLim  = LenW'(MaxPayloadLen + 1);
  localparam logic [LenW-1:0] IdEnd   = LenW'(3);

  phase_e            phase_q, phase_d;
  logic [7:0]        xor_q, xor_d;
  logic [7:0]        sum_q, sum_d;
  logic [1:0]        hex_cnt_q, hex_cnt_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [23:0]       id_q, id_d;
  logic [2:0]        comma_q, comma_d;
  logic              bad_q, bad_d;
  logic [FieldW-1:0] fld_q [3];
  logic [FieldW-1:0] fld_d [3];

  // Multiply by ten and add a digit, saturating at the field maximum.
  function automatic logic [FieldW-1:0] mac10(input logic [FieldW-1:0] v,
                                               input logic [3:0] d);
    logic [FieldW+3:0] acc;
    acc = ({4'b0, v} << 3) + ({4'b0, v} << 1) + {{FieldW{1'b0}}, d};
    return (|acc[FieldW+3:FieldW]) ? {FieldW{1'b1}} : acc[FieldW-1:0];
  endfunction

  function automatic msg_type_e match_type(input logic [23:0] id,
                                           input logic [2:0] commas);
    msg_type_e t;
    t = TYPE_NONE;
    if (id == IdCha && commas == 3'd1) t = TYPE_CHA;
    if (id == IdAcc && commas == 3'd1) t = TYPE_ACC;
    if (id == IdRev && commas == 3'd1) t = TYPE_REV;
    if (id == IdSho && commas == 3'd2) t = TYPE_SHO;
    if (id == IdRes && commas == 3'd3) t = TYPE_RES;
    return t;
  endfunction

  logic      is_dec, is_hex;
  logic [3:0] nib;
  msg_type_e done_type;
  logic      err;

  assign is_dec = (byte_i >= ChZero) && (byte_i <= ChNine);
  assign is_hex = (byte_i >= ChA) && (byte_i <= ChF);
  assign nib    = is_dec ? byte_i[3:0] : byte_i[3:0] + 4'd9;

  always_comb begin
    phase_d   = phase_q;
    xor_d     = xor_q;
    sum_d     = sum_q;
    hex_cnt_d = hex_cnt_q;
    len_d     = len_q;
    id_d      = id_q;
    comma_d   = comma_q;
    bad_d     = bad_q;
    fld_d     = fld_q;
    err       = 1'b0;
    done_type = TYPE_NONE;

    case (phase_q)
      PH_WAIT: begin
        if (byte_i == ChStart) begin
          xor_d     = '0;
          sum_d     = '0;
          hex_cnt_d = '0;
          len_d     = LenW'(1);
          id_d      = '0;
          comma_d   = '0;
          bad_d     = 1'b0;
          fld_d     = '{default: '0};
          phase_d   = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (byte_i == ChNl || byte_i == ChStart || len_q >= SentLim) begin
          err = 1'b1;
        end else if (byte_i == ChStar) begin
          len_d   = len_q + 1'b1;
          phase_d = PH_SUM;
        end else if (len_q >= PayLim) begin
          err = 1'b1;
        end else begin
          xor_d = xor_q ^ byte_i;
          len_d = len_q + 1'b1;
          if (len_q <= IdEnd) begin
            // The first three payload bytes form the identifier.
            id_d = {id_q[15:0], byte_i};
            if (byte_i == ChComma) bad_d = 1'b1;
          end else if (byte_i == ChComma) begin
            if (comma_q != 3'd7) comma_d = comma_q + 1'b1;
          end else if (comma_q == 3'd0 || !is_dec) begin
            bad_d = 1'b1;
          end else begin
            // Only the first three fields are kept; later digits are dropped.
            for (int k = 0; k < 3; k++) begin
              if (comma_q == 3'(k + 1)) fld_d[k] = mac10(fld_q[k], byte_i[3:0]);
            end
          end
        end
      end
      PH_SUM: begin
        if (is_dec || is_hex) begin
          if (hex_cnt_q == 2'd2 || len_q >= SentLim) begin
            err = 1'b1;
          end else begin
            sum_d     = {sum_q[3:0], nib};
            hex_cnt_d = hex_cnt_q + 1'b1;
            len_d     = len_q + 1'b1;
          end
        end else if (byte_i == ChNl) begin
          if (hex_cnt_q == 2'd2 && sum_q == xor_q && !bad_q) begin
            done_type = match_type(id_q, comma_q);
          end
          err     = (done_type == TYPE_NONE);
          phase_d = PH_WAIT;
        end else begin
          err = 1'b1;
        end
      end
      default: begin
        err = 1'b1;
      end
    endcase

    if (err) phase_d = PH_WAIT;
  end

  always_comb begin
    result_o.byte_error   = err;
    result_o.message_done = (done_type != TYPE_NONE);
    result_o.message_type = done_type;
    result_o.field_one    = (done_type != TYPE_NONE) ? fld_q[0] : '0;
    result_o.field_two    = (done_type != TYPE_NONE) ? fld_q[1] : '0;
    result_o.field_three  = (done_type != TYPE_NONE) ? fld_q[2] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_WAIT;
      xor_q     <= '0;
      sum_q     <= '0;
      hex_cnt_q <= '0;
      len_q     <= '0;
      id_q      <= '0;
      comma_q   <= '0;
      bad_q     <= 1'b0;
      fld_q     <= '{default: '0};
    end else if (step_i) begin
      phase_q   <= phase_d;
      xor_q     <= xor_d;
      sum_q     <= sum_d;
      hex_cnt_q <= hex_cnt_d;
      len_q     <= len_d;
      id_q      <= id_d;
      comma_q   <= comma_d;
      bad_q     <= bad_d;
      fld_q     <= fld_d;
    end
  end

endmodule

// File: hw/rtl/framed_sentence_decoder_unit.sv
// Latency: a result item is valid in the cycle after its input item is accepted.
// Throughput: one item per cycle unless results stall; one parser step per item.
// Input ready is high whenever the result register is empty or is being taken.
// Reset (rst_ni low, asynchronous) empties the result register and returns the
// parser to waiting for a start delimiter with all sentence state cleared.
module framed_sentence_decoder_unit #(
  parameter int unsigned MaxSentenceLen = fsd_pkg::MaxSentenceLenDef,
  parameter int unsigned MaxPayloadLen  = fsd_pkg::MaxPayloadLenDef
) (
  input logic           clk_i,
  input logic           rst_ni,
  fsd_byte_if.sink      byte_chan_i,
  fsd_result_if.source  result_chan_o
);
  import fsd_pkg::*;

  // Every accepted byte yields exactly one result item, so the only flow
  // control is the result register: a new byte may enter when that register
  // is free or is being emptied in the same cycle.
  logic        accept;
  logic        out_valid_q;
  fsd_result_t step_res;
  fsd_result_t res_q;

  assign byte_chan_i.ready = !out_valid_q || result_chan_o.ready;
  assign accept            = byte_chan_i.valid && byte_chan_i.ready;

  // The parser holds all sentence state and advances by one byte per accept.
  // Its result is the combinational outcome of the current byte.
  fsd_parser #(
    .MaxSentenceLen (MaxSentenceLen),
    .MaxPayloadLen  (MaxPayloadLen)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (accept),
    .byte_i   (byte_chan_i.byte_in),
    .result_o (step_res)
  );

  // Result register; the payload is loaded only when an item is accepted.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (result_chan_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= step_res;
    end
  end

  assign result_chan_o.valid        = out_valid_q;
  assign result_chan_o.byte_error   = res_q.byte_error;
  assign result_chan_o.message_done = res_q.message_done;
  assign result_chan_o.message_type = res_q.message_type;
  assign result_chan_o.field_one    = res_q.field_one;
  assign result_chan_o.field_two    = res_q.field_two;
  assign result_chan_o.field_three  = res_q.field_three;

  // A sentence cannot both complete and fail on the same byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_q.byte_error && res_q.message_done))
    else $error("result flags both done and error");

  // A type is reported exactly when a sentence completes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((res_q.message_type != TYPE_NONE) == res_q.message_done))
    else $error("message type disagrees with done flag");

  // Every accepted byte leaves a result waiting in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted item produced no result");

  // Fields stay zero unless a sentence completed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_q.message_done) |->
      (res_q.field_one == '0 && res_q.field_two == '0 && res_q.field_three == '0))
    else $error("fields nonzero without a completed sentence");

endmodule
